### rtl/swm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median package
// Shared widths, sequencer states and the structs that pass between modules.
// ----------------------------------------------------------------------------
package swm_pkg;

    // Built depth of the window and the widths that follow from it.
    localparam int MAX_WINDOW = 64;
    localparam int ADDR_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

    // Fixed field widths.
    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = 33;
    localparam int CFG_W    = 7;
    localparam int OUT_W    = 72;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_FLUSH,
        ST_RD_HI,
        ST_RD_LO,
        ST_SUM,
        ST_OUT
    } t_state;

    // One access cycle of a simple dual-port memory.
    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [SAMPLE_W-1:0] wdata;
        logic                re;
        logic [ADDR_W-1:0]   raddr;
    } t_ram_req;

    // Finished result handed from the sequencer to the output stage.
    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] sum;
    } t_result;

endpackage

### rtl/swm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered and returns
// the old contents when the same entry is written in the same cycle.
// ----------------------------------------------------------------------------
module swm_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [WIDTH-1:0]      i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/swm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median sequencer
// Reads the oldest sample from the arrival ring, then streams the sorted
// window through once, dropping the oldest value and merging in the new one,
// and writes the merged list back in place; reads the middle entries if full.
// ----------------------------------------------------------------------------
module swm_seq import swm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [SAMPLE_W-1:0]  i_sample,
    input  logic                 i_first,
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_wsize,
    input  logic [SAMPLE_W-1:0]  i_ring_rdata,
    input  logic [SAMPLE_W-1:0]  i_sort_rdata,
    input  logic                 i_res_ready,
    output logic                 o_in_ready,
    output t_ram_req             o_ring_req,
    output t_ram_req             o_sort_req,
    output t_result              o_res
);

    t_state r_state, n_state;

    logic signed [SAMPLE_W-1:0] r_sample, n_sample;
    logic signed [SAMPLE_W-1:0] r_old, n_old;
    logic signed [SAMPLE_W-1:0] r_carry, n_carry;
    logic signed [SAMPLE_W-1:0] r_hi, n_hi;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    logic [CNT_W-1:0]           r_fill, n_fill;
    logic [ADDR_W-1:0]          r_wp, n_wp;
    logic [CNT_W-1:0]           r_nold, n_nold;
    logic [CNT_W-1:0]           r_proc, n_proc;
    logic [CNT_W-1:0]           r_wr, n_wr;
    logic                       r_full, n_full;
    logic                       r_ins, n_ins;
    logic                       r_rem, n_rem;
    logic                       r_cval, n_cval;

    logic [CNT_W-1:0]           eff;
    logic [CNT_W-1:0]           half;
    logic [CNT_W-1:0]           fill0;
    logic [ADDR_W-1:0]          wp0;
    logic [CNT_W-1:0]           wp_inc;
    logic [CNT_W-1:0]           proc_nxt;
    logic [CNT_W-1:0]           fill_done;
    logic signed [SAMPLE_W-1:0] v;
    logic signed [SAMPLE_W-1:0] p0;
    logic signed [SAMPLE_W-1:0] p1;
    logic [1:0]                 pcnt;
    logic                       wr_en;
    logic signed [SAMPLE_W-1:0] wr_data;

    // Effective window size: zero counts as one, large values saturate.
    always_comb begin
        if (i_wsize == '0) begin
            eff = CNT_W'(1);
        end else if (int'(i_wsize) > MAX_WINDOW) begin
            eff = CNT_W'(MAX_WINDOW);
        end else begin
            eff = CNT_W'(i_wsize);
        end
        half = eff >> 1;
    end

    // Window position at accept time after restart and wrap handling.
    always_comb begin
        fill0 = i_first ? '0 : r_fill;
        wp0   = i_first ? '0 : r_wp;
        if (CNT_W'(wp0) >= eff) begin
            wp0 = '0;
        end
        if (fill0 > eff) begin
            fill0 = '0;
            wp0   = '0;
        end
    end

    // Merge step on one sorted entry: drop the oldest value, insert the new one.
    always_comb begin
        v    = i_sort_rdata;
        p0   = v;
        p1   = v;
        pcnt = 2'd1;
        if (r_full && !r_rem && (v == r_old)) begin
            pcnt = 2'd0;
        end else if (!r_ins && (v > r_sample)) begin
            p0   = r_sample;
            p1   = v;
            pcnt = 2'd2;
        end
    end

    assign proc_nxt  = r_proc + CNT_W'(1);
    assign wp_inc    = CNT_W'(r_wp) + CNT_W'(1);
    assign fill_done = r_wr + CNT_W'(wr_en);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = (r_nold == '0) ? ST_FLUSH : ST_SCAN;
            end
            ST_SCAN: begin
                if (proc_nxt >= r_nold) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_state = (fill_done == eff) ? ST_RD_HI : ST_IDLE;
            end
            ST_RD_HI: n_state = ST_RD_LO;
            ST_RD_LO: n_state = ST_SUM;
            ST_SUM:   n_state = ST_OUT;
            ST_OUT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        o_in_ready  = (r_state == ST_IDLE);
        o_res.valid = (r_state == ST_OUT);
        o_res.sum   = r_sum;
    end

    // Datapath and memory accesses.
    always_comb begin
        n_sample = r_sample;
        n_old    = r_old;
        n_carry  = r_carry;
        n_hi     = r_hi;
        n_sum    = r_sum;
        n_fill   = r_fill;
        n_wp     = r_wp;
        n_nold   = r_nold;
        n_proc   = r_proc;
        n_wr     = r_wr;
        n_full   = r_full;
        n_ins    = r_ins;
        n_rem    = r_rem;
        n_cval   = r_cval;
        wr_en    = 1'b0;
        wr_data  = r_carry;
        o_ring_req = '0;
        o_sort_req = '0;

        case (r_state)
            ST_IDLE: begin
                // Take the word and fetch the ring slot it replaces.
                if (i_in_valid) begin
                    n_sample         = i_sample;
                    n_wp             = wp0;
                    n_nold           = fill0;
                    n_full           = (fill0 == eff);
                    o_ring_req.re    = 1'b1;
                    o_ring_req.raddr = wp0;
                end
            end
            ST_LOAD: begin
                // Latch the oldest sample, store the new one, start the scan.
                n_old            = i_ring_rdata;
                o_ring_req.we    = 1'b1;
                o_ring_req.waddr = r_wp;
                o_ring_req.wdata = r_sample;
                o_sort_req.re    = (r_nold != '0);
                o_sort_req.raddr = '0;
                n_proc           = '0;
                n_wr             = '0;
                n_ins            = 1'b0;
                n_rem            = 1'b0;
                n_cval           = 1'b0;
            end
            ST_SCAN: begin
                // At most one value waits in the carry register.
                if (r_cval) begin
                    wr_en   = 1'b1;
                    wr_data = r_carry;
                    n_carry = p0;
                    n_cval  = (pcnt != 2'd0);
                end else begin
                    wr_en   = (pcnt != 2'd0);
                    wr_data = p0;
                    n_carry = p1;
                    n_cval  = (pcnt == 2'd2);
                end
                if (pcnt == 2'd0) begin
                    n_rem = 1'b1;
                end
                if (pcnt == 2'd2) begin
                    n_ins = 1'b1;
                end
                o_sort_req.we    = wr_en;
                o_sort_req.waddr = r_wr[ADDR_W-1:0];
                o_sort_req.wdata = wr_data;
                n_wr             = r_wr + CNT_W'(wr_en);
                o_sort_req.re    = (proc_nxt < r_nold);
                o_sort_req.raddr = proc_nxt[ADDR_W-1:0];
                n_proc           = proc_nxt;
            end
            ST_FLUSH: begin
                // Write the pending value, or the new sample if it goes last.
                if (r_cval) begin
                    wr_en   = 1'b1;
                    wr_data = r_carry;
                end else if (!r_ins) begin
                    wr_en   = 1'b1;
                    wr_data = r_sample;
                end
                o_sort_req.we    = wr_en;
                o_sort_req.waddr = r_wr[ADDR_W-1:0];
                o_sort_req.wdata = wr_data;
                n_cval           = 1'b0;
                n_ins            = 1'b1;
                n_wr             = fill_done;
                n_fill           = fill_done;
                n_wp             = (wp_inc >= eff) ? '0 : wp_inc[ADDR_W-1:0];
            end
            ST_RD_HI: begin
                o_sort_req.re    = 1'b1;
                o_sort_req.raddr = half[ADDR_W-1:0];
            end
            ST_RD_LO: begin
                n_hi             = i_sort_rdata;
                o_sort_req.re    = 1'b1;
                o_sort_req.raddr = eff[0] ? half[ADDR_W-1:0]
                                          : ADDR_W'(half - CNT_W'(1));
            end
            ST_SUM: begin
                n_sum = SUM_W'($signed(i_sort_rdata)) + SUM_W'(r_hi);
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase

        // A register write empties the window.
        if (i_cfg_we) begin
            n_fill = '0;
            n_wp   = '0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_wp    <= '0;
            r_nold  <= '0;
            r_proc  <= '0;
            r_wr    <= '0;
            r_full  <= 1'b0;
            r_ins   <= 1'b0;
            r_rem   <= 1'b0;
            r_cval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_wp    <= n_wp;
            r_nold  <= n_nold;
            r_proc  <= n_proc;
            r_wr    <= n_wr;
            r_full  <= n_full;
            r_ins   <= n_ins;
            r_rem   <= n_rem;
            r_cval  <= n_cval;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_old    <= n_old;
        r_carry  <= n_carry;
        r_hi     <= n_hi;
        r_sum    <= n_sum;
    end

endmodule

### rtl/sliding_window_median_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median core
// Running median over the last window_size signed samples of a stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample per word; s_axis_tuser set restarts the window
//   before that sample is taken in. m_axis returns one word per sample once
//   the window holds window_size samples: the median (middle sum halved,
//   truncated toward zero) and the exact sum of the two middle values.
//   i_cfg_we writes window_size and empties the window; write it only while
//   the core is idle.
// Timing:
//   Each sample walks the sorted window once through a single memory read
//   port, one entry per cycle. After accept the core latches the oldest
//   sample, scans the fill samples held before the word (zero after a
//   restart) and writes the last value back. A word that gives a result
//   then reads the two middle entries, sums them and hands the result to
//   the output register before the next sample is accepted.
// Reset and stalls:
//   Reset empties the window and sets window_size to 3; memories keep their
//   contents. The output register holds a finished word while m_axis_tready
//   is low, and the core takes the next sample meanwhile; it waits only when
//   a second result is ready before the first has been taken.
// ----------------------------------------------------------------------------
module sliding_window_median_core import swm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata,   // window_size
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [SAMPLE_W-1:0] s_axis_tdata,  // [31:0] sample
    input  logic                s_axis_tuser,  // [0] first
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_W-1:0]    m_axis_tdata   // [31:0] median, [64:32] middle_sum
);

    logic [CFG_W-1:0]    r_wsize;
    logic                r_tvalid, n_tvalid;
    logic [OUT_W-1:0]    r_tdata, n_tdata;
    t_ram_req            ring_req;
    t_ram_req            sort_req;
    t_result             res;
    logic                res_ready;
    logic [SAMPLE_W-1:0] ring_rdata;
    logic [SAMPLE_W-1:0] sort_rdata;
    logic [SUM_W-1:0]    sum_adj;

    // Window size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize <= CFG_W'(3);
        end else if (i_cfg_we) begin
            r_wsize <= i_cfg_wdata;
        end
    end

    // Samples in arrival order.
    swm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_req.we),
        .i_waddr (ring_req.waddr),
        .i_wdata (ring_req.wdata),
        .i_re    (ring_req.re),
        .i_raddr (ring_req.raddr),
        .o_rdata (ring_rdata)
    );

    // Samples in ascending order.
    swm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_sort (
        .i_clk   (i_clk),
        .i_we    (sort_req.we),
        .i_waddr (sort_req.waddr),
        .i_wdata (sort_req.wdata),
        .i_re    (sort_req.re),
        .i_raddr (sort_req.raddr),
        .o_rdata (sort_rdata)
    );

    swm_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_sample     (s_axis_tdata),
        .i_first      (s_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_wsize      (r_wsize),
        .i_ring_rdata (ring_rdata),
        .i_sort_rdata (sort_rdata),
        .i_res_ready  (res_ready),
        .o_in_ready   (s_axis_tready),
        .o_ring_req   (ring_req),
        .o_sort_req   (sort_req),
        .o_res        (res)
    );

    // Halve the middle sum, rounding toward zero.
    assign sum_adj = res.sum + SUM_W'(res.sum[SUM_W-1]);

    // Output register.
    assign res_ready = !r_tvalid || m_axis_tready;

    always_comb begin
        n_tvalid = r_tvalid;
        n_tdata  = r_tdata;
        if (res.valid && res_ready) begin
            n_tvalid = 1'b1;
            n_tdata  = {(OUT_W - SUM_W - SAMPLE_W)'(0), res.sum, sum_adj[SUM_W-1:1]};
        end else if (m_axis_tready) begin
            n_tvalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
        end else begin
            r_tvalid <= n_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tdata <= n_tdata;
    end

    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = r_tdata;

endmodule

### rtl/swm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median port checker
// Watches the ports of the core for handshake and result consistency.
// ----------------------------------------------------------------------------
module swm_checker import swm_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] sum_adj;

    assign sum     = m_axis_tdata[SAMPLE_W+SUM_W-1:SAMPLE_W];
    assign sum_adj = sum + SUM_W'(sum[SUM_W-1]);

    // A stalled result word holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // The median is always the middle sum halved toward zero.
    a_median: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[SAMPLE_W-1:0] == sum_adj[SUM_W-1:1])
        else $error("median does not match middle sum");

    // A sample is taken only after the previous one has been merged.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("sample accepted while the previous one is in work");

    // Reset leaves the core ready and with no result pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready && !m_axis_tvalid)
        else $error("core not idle after reset");

endmodule

bind sliding_window_median_core swm_checker u_swm_checker (.*);
